FILE: sv/rtc_pkg.sv
// Shared types, constants and codes for the columnar route transposition block.
package rtc_pkg;

    localparam int KEY_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int MAX_LEN_DEF = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLUMNS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 1'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_START,
        ST_EMIT
    } rtc_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
        logic       truncated;
    } out_word_t;

    // Control from the sequencer to the route address generator
    typedef struct packed {
        logic start;
        logic advance;
        logic decrypt;
    } route_ctrl_t;

endpackage

FILE: sv/route_transposition_cipher.sv
// Columnar route transposition: a message is loaded one word per cycle, then emitted.
// Load: one input word per cycle; input stalls from the last word until all reads are issued.
// Emit: a start state, then one result word per cycle from the store's single read port while
//   the output buffer has room; each result passes the store's read register and the output register.
// Results drain through an output register and skid register while the next message loads.
// Reset (rst_n low, asynchronous) clears length, flags, walk state and key_columns=1, encrypt.
module route_transposition_cipher
    import rtc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int SW = KEY_W + 1;

    rtc_state_t     state_reg, state_next;
    logic [KEY_W-1:0] key_reg;
    logic             decrypt_reg;
    logic [KEY_W-1:0] key_eff;
    logic [LW-1:0]    len_reg, len_next;
    logic [LW-1:0]    quot_reg, quot_next;
    logic [LW-1:0]    rem_reg, rem_next;
    logic             ovf_reg, ovf_next;
    logic [LW-1:0]    issue_cnt_reg, issue_cnt_next;

    logic             in_acc;
    logic             store_we;
    logic             issue;
    logic             issue_last;
    logic             clear_msg;
    route_ctrl_t      route_ctrl;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;

    logic             pend_reg;
    logic             pend_last_reg;
    logic             pend_trunc_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;
    logic             skid_valid_reg;
    out_word_t        skid_word_reg;
    out_word_t        rd_word;
    logic [1:0]       occ;
    logic             pop;

    assign key_eff  = (key_reg == '0) ? KEY_W'(1) : key_reg;
    assign in_stall = (state_reg != ST_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign store_we = in_acc && (len_reg < LW'(MAX_LEN));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= KEY_W'(1);
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_COLUMNS:  key_reg     <= cfg_data[KEY_W-1:0];
                CFG_DECRYPT_MODE: decrypt_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Output buffer occupancy decides whether another read may go out
    assign occ        = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(pend_reg);
    assign pop        = out_valid_reg && !out_stall;
    assign issue_last = (issue_cnt_reg == (len_reg - LW'(1)));

    // Sequencer: next state and message bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        issue_cnt_next = issue_cnt_reg;
        issue          = 1'b0;
        clear_msg      = 1'b0;
        route_ctrl     = '{start: 1'b0, advance: 1'b0, decrypt: decrypt_reg};
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (store_we)
                    begin
                        len_next = len_reg + LW'(1);
                        if ((SW'(rem_reg) + SW'(1)) == SW'(key_eff))
                        begin
                            rem_next  = '0;
                            quot_next = quot_reg + LW'(1);
                        end
                        else
                        begin
                            rem_next = rem_reg + LW'(1);
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_word.last_in)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                route_ctrl.start = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT:
            begin
                issue = (occ < 2'd2) || ((occ == 2'd2) && pop);
                if (issue)
                begin
                    route_ctrl.advance = 1'b1;
                    issue_cnt_next     = issue_cnt_reg + LW'(1);
                    if (issue_last)
                    begin
                        clear_msg  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (clear_msg)
        begin
            len_next       = '0;
            quot_next      = '0;
            rem_next       = '0;
            ovf_next       = 1'b0;
            issue_cnt_next = '0;
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            len_reg       <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            ovf_reg       <= 1'b0;
            issue_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            issue_cnt_reg <= issue_cnt_next;
        end
    end

    rtc_store #(
        .MAX_LEN (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (in_word.data_byte),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    rtc_route #(
        .MAX_LEN (MAX_LEN)
    ) u_route (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (route_ctrl),
        .key_eff (key_eff),
        .len     (len_reg),
        .quot    (quot_reg),
        .rem     (rem_reg),
        .addr    (rd_addr)
    );

    // Track the read in flight and its flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_last_reg  <= issue_last;
            pend_trunc_reg <= ovf_reg;
        end
    end

    assign rd_word = '{out_byte: rd_data, last_out: pend_last_reg, truncated: pend_trunc_reg};

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= pend_reg;
                end
                else
                begin
                    out_valid_reg <= pend_reg;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= pend_reg;
            end
            else if (pend_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_word_reg <= skid_word_reg;
                if (pend_reg)
                begin
                    skid_word_reg <= rd_word;
                end
            end
            else if (pend_reg)
            begin
                out_word_reg <= rd_word;
            end
        end
        else if (!out_valid_reg)
        begin
            if (pend_reg)
            begin
                out_word_reg <= rd_word;
            end
        end
        else if (pend_reg)
        begin
            skid_word_reg <= rd_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: sv/rtc_store.sv
// Message store: one write port, one registered read port.
module rtc_store
    import rtc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(MAX_LEN)-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic                       re,
    input  logic [$clog2(MAX_LEN)-1:0] raddr,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [MAX_LEN];
    logic [7:0] rdata_reg;

    // Write incoming bytes
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, enabled by re
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rtc_route.sv
// Route address generator: walks the grid in encrypt or decrypt order.
module rtc_route
    import rtc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  route_ctrl_t                  ctrl,
    input  logic [KEY_W-1:0]             key_eff,
    input  logic [$clog2(MAX_LEN+1)-1:0] len,
    input  logic [$clog2(MAX_LEN+1)-1:0] quot,
    input  logic [$clog2(MAX_LEN+1)-1:0] rem,
    output logic [$clog2(MAX_LEN)-1:0]   addr
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int SW = KEY_W + 1;

    logic [LW-1:0] col_reg, col_next;
    logic [LW-1:0] rowk_reg, rowk_next;
    logic [LW-1:0] addr_reg, addr_next;
    logic [LW-1:0] cc_first;
    logic [LW-1:0] cc_right;
    logic [SW-1:0] step_sum;
    logic          key_ge_len;

    // Column heights: quotient plus one for columns left of the remainder
    assign cc_first   = quot + LW'(rem != '0);
    assign cc_right   = quot + LW'((col_reg + LW'(1)) < rem);
    assign step_sum   = SW'(addr_reg) + SW'(key_eff);
    assign key_ge_len = SW'(key_eff) >= SW'(len);

    // Next walk position
    always_comb
    begin
        col_next  = col_reg;
        rowk_next = rowk_reg;
        addr_next = addr_reg;
        if (ctrl.start)
        begin
            if (ctrl.decrypt)
            begin
                col_next  = '0;
                rowk_next = len - cc_first;
                addr_next = len - cc_first;
            end
            else
            begin
                col_next  = key_ge_len ? (len - LW'(1)) : (LW'(key_eff) - LW'(1));
                addr_next = col_next;
            end
        end
        else if (ctrl.advance)
        begin
            if (ctrl.decrypt)
            begin
                if ((SW'(col_reg) + SW'(1)) == SW'(key_eff))
                begin
                    col_next  = '0;
                    rowk_next = rowk_reg + LW'(1);
                    addr_next = rowk_reg + LW'(1);
                end
                else
                begin
                    col_next  = col_reg + LW'(1);
                    addr_next = addr_reg - cc_right;
                end
            end
            else
            begin
                if (step_sum >= SW'(len))
                begin
                    col_next  = col_reg - LW'(1);
                    addr_next = col_reg - LW'(1);
                end
                else
                begin
                    addr_next = LW'(step_sum);
                end
            end
        end
    end

    // Hold walk position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            rowk_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            rowk_reg <= rowk_next;
            addr_reg <= addr_next;
        end
    end

    assign addr = addr_reg[AW-1:0];

endmodule

FILE: sv/rtc_checker.sv
// Port-level checker for the route transposition block, bound to the top level.
module rtc_checker
    import rtc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    logic mid_msg_reg;
    logic trunc_reg;

    // Remember whether a result message is under way and its truncation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_msg_reg <= 1'b0;
            trunc_reg   <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            mid_msg_reg <= !out_word.last_out;
            trunc_reg   <= out_word.truncated;
        end
    end

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // Stop taking input once the last word of a message is in
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.last_in |=> in_stall)
        else $error("input taken right after last word");

    // Keep the truncation flag constant across one result message
    a_trunc_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mid_msg_reg |-> out_word.truncated == trunc_reg)
        else $error("truncated flag changed within a message");

    // Drop output valid once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind route_transposition_cipher rtc_checker u_rtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
